// ===== src/ttsg_pkg.sv =====
// Shared constants, types and quarter-wave sine tables for the three-tone generator.
`timescale 1ns / 1ps

package ttsg_pkg;

  localparam int PHASE_BITS    = 32;
  localparam int NUM_TONES     = 3;
  localparam int MAX_CHANNELS  = 8;
  localparam int CHAN_BITS     = $clog2(MAX_CHANNELS);
  localparam int COUNT_BITS    = 4;
  localparam int TABLE_BITS    = 10;
  localparam int QUARTER_BITS  = TABLE_BITS - 2;
  localparam int QUARTER       = 1 << QUARTER_BITS;
  localparam int MAG_BITS      = 14;
  localparam int SINE_BITS     = MAG_BITS + 1;
  localparam int VALUE_BITS    = 16;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 32;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned Q30_ONE     = 64'd1 << 30;
  localparam longint unsigned SINE_SCALE  = 64'd8192;

  typedef logic [PHASE_BITS-1:0]  phase_t;
  typedef logic [MAG_BITS-1:0]    mag_t;
  typedef mag_t [QUARTER-1:0]     quarter_rom_t;
  typedef logic [CHAN_BITS-1:0]   chan_t;
  typedef logic [COUNT_BITS-1:0]  count_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_TONE_A_STEP = 2'd0,
    REG_TONE_B_STEP = 2'd1,
    REG_TONE_C_STEP = 2'd2,
    REG_CHANNELS    = 2'd3
  } reg_index_t;

  localparam phase_t TONE_A_RESET   = 32'd16421538;
  localparam phase_t TONE_B_RESET   = 32'd6007846;
  localparam phase_t TONE_C_RESET   = 32'd90518900;
  localparam count_t CHANNELS_RESET = 4'd4;

  // series term n divided by (2n-1)(2n) for cos or (2n)(2n+1) for sin
  function automatic longint unsigned series_div(longint unsigned t, int n, bit want_cos);
    case (n)
      1:       return want_cos ? t / 64'd2   : t / 64'd6;
      2:       return want_cos ? t / 64'd12  : t / 64'd20;
      3:       return want_cos ? t / 64'd30  : t / 64'd42;
      4:       return want_cos ? t / 64'd56  : t / 64'd72;
      5:       return want_cos ? t / 64'd90  : t / 64'd110;
      6:       return want_cos ? t / 64'd132 : t / 64'd156;
      7:       return want_cos ? t / 64'd182 : t / 64'd210;
      8:       return want_cos ? t / 64'd240 : t / 64'd272;
      9:       return want_cos ? t / 64'd306 : t / 64'd342;
      10:      return want_cos ? t / 64'd380 : t / 64'd420;
      11:      return want_cos ? t / 64'd462 : t / 64'd506;
      default: return want_cos ? t / 64'd552 : t / 64'd600;
    endcase
  endfunction

  // Q30 Taylor series of sin or cos over the first quadrant, scaled to 8192.
  function automatic mag_t quarter_entry(int unsigned rem, bit want_cos);
    longint unsigned theta;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint unsigned scaled;
    theta = (HALF_PI_Q30 * longint'(rem)) / QUARTER;
    x2    = (theta * theta) >> 30;
    term  = want_cos ? Q30_ONE : theta;
    sum   = longint'(term);
    for (int n = 1; n <= 12; n++) begin
      term = series_div((term * x2) >> 30, n, want_cos);
      if ((n % 2) == 1) sum = sum - longint'(term);
      else              sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > longint'(Q30_ONE)) sum = longint'(Q30_ONE);
    scaled = ((longint'(sum) * SINE_SCALE) + (64'd1 << 29)) >> 30;
    return scaled[MAG_BITS-1:0];
  endfunction

  function automatic quarter_rom_t build_rom(bit want_cos);
    quarter_rom_t rom;
    for (int k = 0; k < QUARTER; k++) begin
      rom[k] = quarter_entry(k, want_cos);
    end
    return rom;
  endfunction

  localparam quarter_rom_t SIN_ROM = build_rom(1'b0);
  localparam quarter_rom_t COS_ROM = build_rom(1'b1);

endpackage

// ===== src/ttsg_sine.sv =====
// Sine lookup for one phase: quadrant fold over two quarter-wave tables.
`timescale 1ns / 1ps

module ttsg_sine (
  input  logic [ttsg_pkg::TABLE_BITS-1:0]       index,
  output logic signed [ttsg_pkg::SINE_BITS-1:0] sine
);

  logic [1:0]                          quad;
  logic [ttsg_pkg::QUARTER_BITS-1:0]   rem;
  ttsg_pkg::mag_t                      mag;
  logic signed [ttsg_pkg::SINE_BITS-1:0] mag_s;

  assign quad  = index[ttsg_pkg::TABLE_BITS-1 -: 2];
  assign rem   = index[ttsg_pkg::QUARTER_BITS-1:0];
  // odd quadrants run on the cosine table, the lower half-circle is negated
  assign mag   = quad[0] ? ttsg_pkg::COS_ROM[rem] : ttsg_pkg::SIN_ROM[rem];
  assign mag_s = $signed({1'b0, mag});
  assign sine  = quad[1] ? -mag_s : mag_s;

endmodule

// ===== src/three_tone_test_signal_generator.sv =====
// Top level: three phase accumulators, channel sequencer and result register.
`timescale 1ns / 1ps

// Flow: an accepted tick loads its start phases into the accumulators; channel 0 then moves
//   into the sample register, and each further channel follows as the sample port takes words.
// A tick yields max(1, min(channels_in_use, 8)) channel words, one per cycle on the single
//   sample port unless it stalls; the next tick is taken as its last channel is registered.
// Reset (rst, synchronous): phases cleared, steps and channel count to defaults, port empty.
module three_tone_test_signal_generator (
  input  logic                                   clk,
  input  logic                                   rst,
  // tick channel
  input  logic                                   tick_valid,
  output logic                                   tick_stall,
  input  logic                                   restart,
  // sample channel
  output logic                                   sample_valid,
  input  logic                                   sample_stall,
  output logic [ttsg_pkg::CHAN_BITS-1:0]         channel,
  output logic signed [ttsg_pkg::VALUE_BITS-1:0] value,
  output logic                                   last,
  // configuration write channel
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [ttsg_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [ttsg_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

  localparam int NT = ttsg_pkg::NUM_TONES;

  // configuration registers
  ttsg_pkg::phase_t tone_step [NT];
  ttsg_pkg::count_t channels_in_use;

  // tone accumulators; base is the tick's starting phase, acc the current channel's
  ttsg_pkg::phase_t tone_phase [NT];
  ttsg_pkg::phase_t base [NT];
  ttsg_pkg::phase_t acc  [NT];

  // channel sequencer
  logic           busy;
  ttsg_pkg::chan_t chan;
  ttsg_pkg::chan_t last_chan;

  logic            advance;
  logic            emit_last;
  logic            tick_take;
  ttsg_pkg::chan_t last_chan_next;
  ttsg_pkg::phase_t start_phase [NT];

  logic signed [ttsg_pkg::SINE_BITS-1:0]  sine [NT];
  logic signed [ttsg_pkg::VALUE_BITS-1:0] sum;

  assign cfg_ready = 1'b1;

  // output register frees up when empty or taken this cycle
  assign advance    = !sample_valid || !sample_stall;
  assign emit_last  = busy && advance && (chan == last_chan);
  assign tick_stall = busy && !emit_last;
  assign tick_take  = tick_valid && !tick_stall;

  // zero channels acts as one, more than the maximum saturates
  always_comb begin
    if (channels_in_use == '0) begin
      last_chan_next = '0;
    end else if (channels_in_use > ttsg_pkg::count_t'(ttsg_pkg::MAX_CHANNELS)) begin
      last_chan_next = ttsg_pkg::chan_t'(ttsg_pkg::MAX_CHANNELS - 1);
    end else begin
      last_chan_next = ttsg_pkg::chan_t'(channels_in_use - 4'd1);
    end
  end

  always_comb begin
    for (int t = 0; t < NT; t++) begin
      start_phase[t] = restart ? '0 : tone_phase[t];
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      tone_step[0]    <= ttsg_pkg::TONE_A_RESET;
      tone_step[1]    <= ttsg_pkg::TONE_B_RESET;
      tone_step[2]    <= ttsg_pkg::TONE_C_RESET;
      channels_in_use <= ttsg_pkg::CHANNELS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ttsg_pkg::REG_TONE_A_STEP: tone_step[0] <= cfg_data;
        ttsg_pkg::REG_TONE_B_STEP: tone_step[1] <= cfg_data;
        ttsg_pkg::REG_TONE_C_STEP: tone_step[2] <= cfg_data;
        ttsg_pkg::REG_CHANNELS:    channels_in_use <= cfg_data[ttsg_pkg::COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // tone phases advance once per accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < NT; t++) begin
        tone_phase[t] <= '0;
      end
    end else if (tick_take) begin
      for (int t = 0; t < NT; t++) begin
        tone_phase[t] <= start_phase[t] + tone_step[t];
      end
    end
  end

  // sequencer: channel c+1 phase = channel c phase + base, mod 2^32
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      chan <= '0;
    end else if (tick_take) begin
      busy <= 1'b1;
      chan <= '0;
    end else if (busy && advance) begin
      busy <= (chan != last_chan);
      chan <= chan + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_take) begin
      last_chan <= last_chan_next;
      for (int t = 0; t < NT; t++) begin
        base[t] <= start_phase[t];
        acc[t]  <= start_phase[t];
      end
    end else if (busy && advance) begin
      for (int t = 0; t < NT; t++) begin
        acc[t] <= acc[t] + base[t];
      end
    end
  end

  for (genvar g = 0; g < NT; g++) begin : g_tone
    ttsg_sine u_sine (
      .index (acc[g][ttsg_pkg::PHASE_BITS-1 -: ttsg_pkg::TABLE_BITS]),
      .sine  (sine[g])
    );
  end

  assign sum = ttsg_pkg::VALUE_BITS'(sine[0]) + ttsg_pkg::VALUE_BITS'(sine[1])
             + ttsg_pkg::VALUE_BITS'(sine[2]);

  // sample register
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (advance) begin
      sample_valid <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && busy) begin
      channel <= chan;
      value   <= sum;
      last    <= (chan == last_chan);
    end
  end

`ifndef NO_ASSERTIONS
  a_take_starts_busy: assert property (@(posedge clk) disable iff (rst)
    tick_valid && !tick_stall |=> busy && (chan == '0))
    else $error("accepted tick did not start at channel 0");

  a_idle_never_stalls: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !tick_stall)
    else $error("tick stalled while sequencer idle");

  a_chan_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> chan <= last_chan)
    else $error("channel counter ran past last channel");

  a_emit_fills_output: assert property (@(posedge clk) disable iff (rst)
    busy && advance |=> sample_valid)
    else $error("channel advanced without a sample word");
`endif

endmodule
